>>> sv/stt_pkg.sv
package stt_pkg;

  localparam int unsigned LINE_BITS   = 20;
  localparam int unsigned COLUMN_BITS = 16;
  localparam int unsigned LENGTH_BITS = 16;

  // Result queue: four entries, so that a two-token request can always be taken
  // while at least two entries are free.
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_FF    = 8'h0c;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_POINT = 8'h2e;
  localparam logic [7:0] CHAR_SEMI  = 8'h3b;
  localparam logic [7:0] CHAR_UNDER = 8'h5f;
  localparam logic [7:0] CHAR_OPEN  = 8'h7b;
  localparam logic [7:0] CHAR_CLOSE = 8'h7d;

  typedef enum logic [3:0] {
    KIND_END       = 4'd0,
    KIND_WORD      = 4'd1,
    KIND_INT       = 4'd2,
    KIND_DECIMAL   = 4'd3,
    KIND_POINT     = 4'd4,
    KIND_SEMI      = 4'd5,
    KIND_OPEN      = 4'd6,
    KIND_CLOSE     = 4'd7,
    KIND_DIRECTIVE = 4'd8,
    KIND_OTHER     = 4'd9
  } kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_WORD    = 3'd1,
    MODE_INT     = 3'd2,
    MODE_DECIMAL = 3'd3,
    MODE_POINT   = 3'd4,
    MODE_DIR     = 3'd5
  } mode_e;

  typedef struct packed {
    kind_e                   kind;
    logic [LINE_BITS-1:0]    line;
    logic [COLUMN_BITS-1:0]  column;
    logic [LENGTH_BITS-1:0]  length;
    logic                    last;
  } token_t;

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

>>> sv/stt_in_if.sv
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] input_char;
  logic       end_of_stream;

  modport source (output valid, input ready, output input_char, output end_of_stream);
  modport sink (input valid, output ready, input input_char, input end_of_stream);
endinterface

>>> sv/stt_out_if.sv
interface stt_out_if;
  logic                               valid;
  logic                               ready;
  logic [3:0]                         token_kind;
  logic [stt_pkg::LINE_BITS-1:0]      token_row;
  logic [stt_pkg::COLUMN_BITS-1:0]    token_column;
  logic [stt_pkg::LENGTH_BITS-1:0]    token_length;
  logic                               last;

  modport source (output valid, input ready, output token_kind, output token_row,
                  output token_column, output token_length, output last);
  modport sink (input valid, output ready, input token_kind, input token_row,
                input token_column, input token_length, input last);
endinterface

>>> sv/source_text_tokenizer.sv
// Source text tokenizer: takes one source byte per request and emits tokens as
// kind, start line, start column and length, with last marking the final token
// caused by a request. A request is taken in every cycle while at least two of
// the four entries of the result queue are free, so a steady stream runs at one
// character per cycle; a token is registered into the queue when the request
// that completes it is taken. A request yields zero, one or two tokens (two when
// a pending token is closed by a semicolon, brace or other single-character
// token, and at end of stream with a token pending), and the output drains one
// token per cycle while the receiver is ready, so the sustained rate is bounded
// by the output. End of stream flushes the pending token, emits the end token at
// the current position and leaves the line and column counts running. Line,
// column and length saturate at their maximum.
module source_text_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  stt_in_if.sink     in_i,
  stt_out_if.source  out_o
);

  // Scanner state.
  stt_pkg::mode_e                     mode_q, mode_d;
  logic [stt_pkg::LINE_BITS-1:0]      line_q, line_d;
  logic [stt_pkg::COLUMN_BITS-1:0]    col_q, col_d;
  logic [stt_pkg::LINE_BITS-1:0]      sline_q, sline_d;
  logic [stt_pkg::COLUMN_BITS-1:0]    scol_q, scol_d;
  logic [stt_pkg::LENGTH_BITS-1:0]    len_q, len_d;

  // Result queue.
  stt_pkg::token_t                    queue_q [stt_pkg::QUEUE_DEPTH];
  logic [stt_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [stt_pkg::QUEUE_CNT_BITS-1:0] count_q;

  logic            in_acc, out_pop;
  logic [1:0]      n_tok;
  stt_pkg::token_t slot0, slot1;

  // Step logic
  logic [7:0]         c;
  logic               more;
  stt_pkg::mode_e     mode_ext;
  logic               has_pend;
  stt_pkg::kind_e     pend_kind;
  logic               has_flush;
  logic               has_b;
  stt_pkg::token_t    tok_flush, tok_b;
  logic               blank;
  logic [stt_pkg::LINE_BITS-1:0]   line_inc;
  logic [stt_pkg::COLUMN_BITS-1:0] col_inc;
  logic [stt_pkg::LENGTH_BITS-1:0] len_inc;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_pop = out_o.valid && out_o.ready;
  assign c       = in_i.input_char;

  assign line_inc = (line_q == '1) ? line_q : line_q + 1'b1;
  assign col_inc  = (col_q == '1) ? col_q : col_q + 1'b1;
  assign len_inc  = (len_q == '1) ? len_q : len_q + 1'b1;

  assign blank = (c == stt_pkg::CHAR_TAB) || (c == stt_pkg::CHAR_SPACE) ||
                 (c == stt_pkg::CHAR_CR) || (c == stt_pkg::CHAR_FF);

  // Does the character continue the pending token, and which mode follows.
  always_comb begin
    more     = 1'b0;
    mode_ext = mode_q;
    unique case (mode_q)
      stt_pkg::MODE_WORD: begin
        more = stt_pkg::is_letter(c) || stt_pkg::is_digit(c) || (c == stt_pkg::CHAR_UNDER);
      end
      stt_pkg::MODE_INT: begin
        if (c == stt_pkg::CHAR_POINT) begin
          more     = 1'b1;
          mode_ext = stt_pkg::MODE_DECIMAL;
        end else begin
          more = stt_pkg::is_digit(c);
        end
      end
      stt_pkg::MODE_DECIMAL: begin
        more = stt_pkg::is_digit(c);
      end
      stt_pkg::MODE_POINT: begin
        if (stt_pkg::is_digit(c)) begin
          more     = 1'b1;
          mode_ext = stt_pkg::MODE_DECIMAL;
        end
      end
      stt_pkg::MODE_DIR: begin
        more = stt_pkg::is_letter(c) || stt_pkg::is_digit(c) ||
               (c == stt_pkg::CHAR_UNDER) || (c == stt_pkg::CHAR_MINUS);
      end
      default: begin
        more = 1'b0;
      end
    endcase
  end

  always_comb begin
    has_pend  = 1'b1;
    pend_kind = stt_pkg::KIND_WORD;
    unique case (mode_q)
      stt_pkg::MODE_WORD:    pend_kind = stt_pkg::KIND_WORD;
      stt_pkg::MODE_INT:     pend_kind = stt_pkg::KIND_INT;
      stt_pkg::MODE_DECIMAL: pend_kind = stt_pkg::KIND_DECIMAL;
      stt_pkg::MODE_POINT:   pend_kind = stt_pkg::KIND_POINT;
      stt_pkg::MODE_DIR:     pend_kind = stt_pkg::KIND_DIRECTIVE;
      default:               has_pend  = 1'b0;
    endcase
  end

  // Next state and the tokens of the current request. The flushed token, if
  // any, always comes first; the second candidate is the end token or a
  // single-character token.
  always_comb begin
    mode_d    = mode_q;
    line_d    = line_q;
    col_d     = col_q;
    sline_d   = sline_q;
    scol_d    = scol_q;
    len_d     = len_q;
    has_flush = 1'b0;
    has_b     = 1'b0;
    tok_flush = '{kind: pend_kind, line: sline_q, column: scol_q, length: len_q,
                  last: 1'b0};
    tok_b     = '{kind: stt_pkg::KIND_END, line: line_q, column: col_q, length: '0,
                  last: 1'b0};

    if (in_i.end_of_stream) begin
      has_flush = has_pend;
      has_b     = 1'b1;
      mode_d    = stt_pkg::MODE_IDLE;
      len_d     = '0;
    end else if (more) begin
      mode_d = mode_ext;
      len_d  = len_inc;
      col_d  = col_inc;
    end else begin
      has_flush = has_pend;
      mode_d    = stt_pkg::MODE_IDLE;
      len_d     = '0;
      if (c == stt_pkg::CHAR_LF) begin
        line_d = line_inc;
        col_d  = {{(stt_pkg::COLUMN_BITS-1){1'b0}}, 1'b1};
      end else begin
        col_d = col_inc;
        if (!blank) begin
          sline_d = line_q;
          scol_d  = col_q;
          len_d   = {{(stt_pkg::LENGTH_BITS-1){1'b0}}, 1'b1};
          priority if (stt_pkg::is_letter(c)) begin
            mode_d = stt_pkg::MODE_WORD;
          end else if (stt_pkg::is_digit(c)) begin
            mode_d = stt_pkg::MODE_INT;
          end else if (c == stt_pkg::CHAR_POINT) begin
            mode_d = stt_pkg::MODE_POINT;
          end else if (c == stt_pkg::CHAR_HASH) begin
            mode_d = stt_pkg::MODE_DIR;
          end else begin
            // Single-character token, emitted right away.
            has_b        = 1'b1;
            len_d        = '0;
            tok_b.length = {{(stt_pkg::LENGTH_BITS-1){1'b0}}, 1'b1};
            priority if (c == stt_pkg::CHAR_SEMI) begin
              tok_b.kind = stt_pkg::KIND_SEMI;
            end else if (c == stt_pkg::CHAR_OPEN) begin
              tok_b.kind = stt_pkg::KIND_OPEN;
            end else if (c == stt_pkg::CHAR_CLOSE) begin
              tok_b.kind = stt_pkg::KIND_CLOSE;
            end else begin
              tok_b.kind = stt_pkg::KIND_OTHER;
            end
          end
        end
      end
    end

    // Pack the tokens into consecutive queue slots and mark the final one.
    n_tok = {1'b0, has_flush} + {1'b0, has_b};
    slot1 = tok_b;
    slot1.last = 1'b1;
    if (has_flush) begin
      slot0 = tok_flush;
      slot0.last = !has_b;
    end else begin
      slot0 = tok_b;
      slot0.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= stt_pkg::MODE_IDLE;
      line_q  <= {{(stt_pkg::LINE_BITS-1){1'b0}}, 1'b1};
      col_q   <= {{(stt_pkg::COLUMN_BITS-1){1'b0}}, 1'b1};
      sline_q <= {{(stt_pkg::LINE_BITS-1){1'b0}}, 1'b1};
      scol_q  <= {{(stt_pkg::COLUMN_BITS-1){1'b0}}, 1'b1};
      len_q   <= '0;
    end else if (in_acc) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      col_q   <= col_d;
      sline_q <= sline_d;
      scol_q  <= scol_d;
      len_q   <= len_d;
    end
  end

  // Result queue: up to two writes per cycle at consecutive entries, one read.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (n_tok != 2'd0) begin
        queue_q[wr_ptr_q] <= slot0;
      end
      if (n_tok == 2'd2) begin
        queue_q[wr_ptr_q + 1'b1] <= slot1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr_q <= wr_ptr_q + n_tok[stt_pkg::QUEUE_PTR_BITS-1:0];
      end
      if (out_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q
               + (in_acc ? {{(stt_pkg::QUEUE_CNT_BITS-2){1'b0}}, n_tok} : '0)
               - {{(stt_pkg::QUEUE_CNT_BITS-1){1'b0}}, out_pop};
    end
  end

  // A request is taken whenever two entries are free, whatever the output does.
  assign in_i.ready = (count_q <= stt_pkg::QUEUE_CNT_BITS'(stt_pkg::QUEUE_DEPTH - 2));

  assign out_o.valid        = (count_q != '0);
  assign out_o.token_kind   = queue_q[rd_ptr_q].kind;
  assign out_o.token_row    = queue_q[rd_ptr_q].line;
  assign out_o.token_column = queue_q[rd_ptr_q].column;
  assign out_o.token_length = queue_q[rd_ptr_q].length;
  assign out_o.last         = queue_q[rd_ptr_q].last;

endmodule

>>> sv/stt_checker.sv
module stt_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [3:0]                       token_kind_i,
  input logic [stt_pkg::LINE_BITS-1:0]    token_row_i,
  input logic [stt_pkg::COLUMN_BITS-1:0]  token_column_i,
  input logic [stt_pkg::LENGTH_BITS-1:0]  token_length_i,
  input logic                             last_i
);

  // A stalled token stays on the output unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(token_kind_i) &&
    $stable(token_row_i) && $stable(token_column_i) && $stable(token_length_i) &&
    $stable(last_i))
    else $error("stalled token changed");

  // The end token is always the final token of its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (token_kind_i == stt_pkg::KIND_END) |-> last_i)
    else $error("end token without last");

  // Only the end token has zero length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (token_kind_i != stt_pkg::KIND_END) |-> (token_length_i != '0))
    else $error("empty token");

  // Positions count from one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (token_row_i != '0) && (token_column_i != '0))
    else $error("token position zero");

  // A token taken without last is followed by the rest of its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=> out_valid_i)
    else $error("second token of a request missing");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .token_kind_i   (out_o.token_kind),
  .token_row_i    (out_o.token_row),
  .token_column_i (out_o.token_column),
  .token_length_i (out_o.token_length),
  .last_i         (out_o.last)
);

>>> tb/sv/stt_token_check.sv
`timescale 1ns / 1ps

// Watches both channels of the tokenizer, predicts the tokens of every
// accepted request and compares every accepted token with the oldest one
// that is still owed.
module stt_token_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  stt_in_if           in_mon,
  stt_out_if          out_mon,
  output int unsigned fail_count_o,
  output int unsigned owed_count_o
);

  stt_pkg::mode_e                  scan_mode_q;
  logic [stt_pkg::LINE_BITS-1:0]   line_q;
  logic [stt_pkg::LINE_BITS-1:0]   start_line_q;
  logic [stt_pkg::COLUMN_BITS-1:0] col_q;
  logic [stt_pkg::COLUMN_BITS-1:0] start_col_q;
  logic [stt_pkg::LENGTH_BITS-1:0] len_q;

  stt_pkg::token_t expected_tokens[$];
  stt_pkg::token_t fresh_tokens[$];

  function automatic stt_pkg::token_t make_token(stt_pkg::kind_e k,
                                                 logic [stt_pkg::LINE_BITS-1:0] l,
                                                 logic [stt_pkg::COLUMN_BITS-1:0] c,
                                                 logic [stt_pkg::LENGTH_BITS-1:0] n);
    stt_pkg::token_t t;
    t.kind   = k;
    t.line   = l;
    t.column = c;
    t.length = n;
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic logic char_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic char_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Emits the token under construction, if any, and returns to idle.
  function automatic void close_pending();
    stt_pkg::kind_e k;
    case (scan_mode_q)
      stt_pkg::MODE_WORD:    k = stt_pkg::KIND_WORD;
      stt_pkg::MODE_INT:     k = stt_pkg::KIND_INT;
      stt_pkg::MODE_DECIMAL: k = stt_pkg::KIND_DECIMAL;
      stt_pkg::MODE_POINT:   k = stt_pkg::KIND_POINT;
      stt_pkg::MODE_DIR:     k = stt_pkg::KIND_DIRECTIVE;
      default: begin
        scan_mode_q = stt_pkg::MODE_IDLE;
        return;
      end
    endcase
    fresh_tokens = {fresh_tokens, make_token(k, start_line_q, start_col_q, len_q)};
    scan_mode_q = stt_pkg::MODE_IDLE;
    len_q       = '0;
  endfunction

  function automatic void scan_request(logic [7:0] ch, logic eos);
    logic           grows;
    stt_pkg::kind_e k;
    fresh_tokens.delete();
    if (eos) begin
      close_pending();
      fresh_tokens = {fresh_tokens, make_token(stt_pkg::KIND_END, line_q, col_q, '0)};
    end else begin
      grows = 1'b0;
      case (scan_mode_q)
        stt_pkg::MODE_WORD: grows = char_alpha(ch) || char_num(ch) ||
                                    ch == stt_pkg::CHAR_UNDER;
        stt_pkg::MODE_INT: begin
          if (ch == stt_pkg::CHAR_POINT) begin
            scan_mode_q = stt_pkg::MODE_DECIMAL;
            grows       = 1'b1;
          end else begin
            grows = char_num(ch);
          end
        end
        stt_pkg::MODE_DECIMAL: grows = char_num(ch);
        stt_pkg::MODE_POINT: begin
          if (char_num(ch)) begin
            scan_mode_q = stt_pkg::MODE_DECIMAL;
            grows       = 1'b1;
          end
        end
        stt_pkg::MODE_DIR: grows = char_alpha(ch) || char_num(ch) ||
                                   ch == stt_pkg::CHAR_UNDER || ch == stt_pkg::CHAR_MINUS;
        default: ;
      endcase
      if (grows) begin
        if (len_q != {stt_pkg::LENGTH_BITS{1'b1}}) len_q++;
      end else begin
        close_pending();
        if (ch == stt_pkg::CHAR_LF) begin
          if (line_q != {stt_pkg::LINE_BITS{1'b1}}) line_q++;
          col_q = stt_pkg::COLUMN_BITS'(1);
        end else if (!(ch == stt_pkg::CHAR_TAB || ch == stt_pkg::CHAR_SPACE ||
                       ch == stt_pkg::CHAR_CR || ch == stt_pkg::CHAR_FF)) begin
          start_line_q = line_q;
          start_col_q  = col_q;
          len_q        = stt_pkg::LENGTH_BITS'(1);
          if (char_alpha(ch)) scan_mode_q = stt_pkg::MODE_WORD;
          else if (char_num(ch)) scan_mode_q = stt_pkg::MODE_INT;
          else if (ch == stt_pkg::CHAR_POINT) scan_mode_q = stt_pkg::MODE_POINT;
          else if (ch == stt_pkg::CHAR_HASH) scan_mode_q = stt_pkg::MODE_DIR;
          else begin
            if (ch == stt_pkg::CHAR_SEMI) k = stt_pkg::KIND_SEMI;
            else if (ch == stt_pkg::CHAR_OPEN) k = stt_pkg::KIND_OPEN;
            else if (ch == stt_pkg::CHAR_CLOSE) k = stt_pkg::KIND_CLOSE;
            else k = stt_pkg::KIND_OTHER;
            fresh_tokens = {fresh_tokens,
                            make_token(k, line_q, col_q, stt_pkg::LENGTH_BITS'(1))};
            len_q = '0;
          end
        end
      end
      // A newline has already restarted the column at one.
      if (ch != stt_pkg::CHAR_LF && col_q != {stt_pkg::COLUMN_BITS{1'b1}}) col_q++;
    end
    if (fresh_tokens.size() != 0) fresh_tokens[fresh_tokens.size() - 1].last = 1'b1;
    expected_tokens = {expected_tokens, fresh_tokens};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stt_pkg::token_t want;
    if (!rst_ni) begin
      scan_mode_q  = stt_pkg::MODE_IDLE;
      line_q       = stt_pkg::LINE_BITS'(1);
      start_line_q = stt_pkg::LINE_BITS'(1);
      col_q        = stt_pkg::COLUMN_BITS'(1);
      start_col_q  = stt_pkg::COLUMN_BITS'(1);
      len_q        = '0;
      expected_tokens.delete();
      fail_count_o = 0;
    end else begin
      // A token leaving now was caused by an earlier request, so the
      // output side is checked before this edge's request is predicted.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_tokens.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected token, expected none, actual kind %0d line %0d",
                   $time, out_mon.token_kind, out_mon.token_row);
          $display("%0t:   actual column %0d length %0d last %0b", $time,
                   out_mon.token_column, out_mon.token_length, out_mon.last);
        end else begin
          want = expected_tokens.pop_front();
          if (out_mon.token_kind !== want.kind || out_mon.token_row !== want.line ||
              out_mon.token_column !== want.column ||
              out_mon.token_length !== want.length || out_mon.last !== want.last) begin
            fail_count_o++;
            $display("%0t: token mismatch, expected kind %0d line %0d column %0d",
                     $time, want.kind, want.line, want.column);
            $display("%0t:   expected length %0d last %0b", $time, want.length,
                     want.last);
            $display("%0t:   actual kind %0d line %0d column %0d length %0d last %0b",
                     $time, out_mon.token_kind, out_mon.token_row,
                     out_mon.token_column, out_mon.token_length, out_mon.last);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) scan_request(in_mon.input_char, in_mon.end_of_stream);
    end
    owed_count_o = expected_tokens.size();
  end

endmodule

>>> tb/sv/tb_source_text_tokenizer.sv
`timescale 1ns / 1ps

// Testbench of the source text tokenizer. The top only makes stimulus and
// gives the verdict; stt_token_check sits beside the block, predicts every
// token and compares. The stimulus is a directed opening, then random source
// text with end of stream now and then, and end of stream at the very end.
// Both sides idle at random, with calm stretches in between.
module tb_source_text_tokenizer;

  // Far beyond the slowest correct run of about 1150 requests, each with at
  // most two tokens, even with the longest sender gaps and receiver stalls on
  // every one.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  logic clk_i;
  logic rst_ni;

  stt_in_if  in_ch ();
  stt_out_if out_ch ();

  int unsigned mismatches;
  int unsigned tokens_owed;
  int unsigned requests_sent;
  int unsigned cycle_count;

  // Sender pacing: a count of requests left in a calm stretch without gaps.
  int unsigned sender_calm;

  // Receiver pacing: cycles left in the current stall and in a calm stretch.
  int unsigned sink_hold;
  int unsigned sink_calm;
  int unsigned sink_roll;

  source_text_tokenizer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  stt_token_check checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (mismatches),
    .owed_count_o (tokens_owed)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Every input of the block is known from time zero on.
  initial begin
    in_ch.valid         = 1'b0;
    in_ch.input_char    = 8'h00;
    in_ch.end_of_stream = 1'b0;
    out_ch.ready        = 1'b0;
    sink_hold           = 0;
    sink_calm           = 0;
  end

  // The receiver stalls at random: mostly short stalls, now and then a long
  // one, and now and then a long stretch of steady acceptance.
  always @(negedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (sink_calm != 0) begin
        sink_calm--;
      end else begin
        sink_roll = $urandom_range(0, 99);
        if (sink_roll < 3) sink_hold = $urandom_range(10, 40);
        else if (sink_roll < 30) sink_hold = $urandom_range(1, 3);
        else if (sink_roll < 32) sink_calm = $urandom_range(50, 200);
      end
    end
  end

  // The run ends here if the block stops making progress.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[source_text_tokenizer] ERROR");
    $finish;
  end

  // Picks the idle cycles before the next request.
  function automatic int unsigned sender_gap();
    int unsigned roll;
    if (sender_calm != 0) begin
      sender_calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      sender_calm = $urandom_range(40, 150);
      return 0;
    end
    if (roll < 5) return $urandom_range(8, 40);
    if (roll < 30) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Drives one request at a falling edge and holds it until the block takes
  // it. Valid is only lowered when a gap is wanted, so it is never lowered
  // and raised within the same time step.
  task automatic send_request(logic [7:0] ch, logic eos);
    int unsigned gap;
    gap = sender_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.input_char    <= ch;
    in_ch.end_of_stream <= eos;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    requests_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
  endtask

  // The sender pauses until the block has delivered every owed token.
  task automatic wait_drained();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (tokens_owed != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) == 0) return 8'("a") + 8'($urandom_range(0, 25));
    return 8'("A") + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0") + 8'($urandom_range(0, 9));
  endfunction

  // A character that continues a word, or a directive when minus is allowed.
  function automatic logic [7:0] rand_tail(bit with_minus);
    case ($urandom_range(0, with_minus ? 4 : 3))
      0, 1: return rand_letter();
      2: return rand_digit();
      3: return stt_pkg::CHAR_UNDER;
      default: return stt_pkg::CHAR_MINUS;
    endcase
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 5))
      0, 1: return stt_pkg::CHAR_SPACE;
      2: return stt_pkg::CHAR_TAB;
      3: return stt_pkg::CHAR_CR;
      4: return stt_pkg::CHAR_FF;
      default: return stt_pkg::CHAR_LF;
    endcase
  endfunction

  // Token lengths are mostly short, with an occasional long one.
  function automatic int unsigned rand_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(7, 24);
    return $urandom_range(0, 6);
  endfunction

  task automatic send_digits(int unsigned n);
    repeat (n) send_request(rand_digit(), 1'b0);
  endtask

  // One piece of source text: mostly well-formed tokens with random content,
  // some blanks, some arbitrary bytes, and now and then an end of stream.
  // Tokens often abut, so that one character closes a token and starts the
  // next.
  task automatic random_fragment();
    int unsigned n;
    case ($urandom_range(0, 19))
      0, 1, 2, 3: begin
        send_request(rand_letter(), 1'b0);
        n = rand_len();
        repeat (n) send_request(rand_tail(1'b0), 1'b0);
      end
      4, 5, 6: send_digits($urandom_range(1, 5));
      7: begin
        send_digits($urandom_range(1, 4));
        send_request(stt_pkg::CHAR_POINT, 1'b0);
        send_digits($urandom_range(1, 4));
      end
      8: begin
        send_request(stt_pkg::CHAR_POINT, 1'b0);
        send_digits($urandom_range(1, 4));
      end
      9: begin
        send_digits($urandom_range(1, 3));
        send_request(stt_pkg::CHAR_POINT, 1'b0);
      end
      10: send_request(stt_pkg::CHAR_POINT, 1'b0);
      11: send_request(stt_pkg::CHAR_SEMI, 1'b0);
      12: send_request(stt_pkg::CHAR_OPEN, 1'b0);
      13: send_request(stt_pkg::CHAR_CLOSE, 1'b0);
      14: begin
        send_request(stt_pkg::CHAR_HASH, 1'b0);
        n = rand_len();
        repeat (n) send_request(rand_tail(1'b1), 1'b0);
      end
      15: send_request(8'($urandom_range(0, 255)), 1'b0);
      16, 17, 18: begin
        n = $urandom_range(1, 3);
        repeat (n) send_request(rand_blank(), 1'b0);
      end
      default: begin
        // The character beside an end of stream is ignored, but its bits
        // still vary.
        if ($urandom_range(0, 2) == 0) begin
          send_request(8'($urandom_range(0, 255)), 1'b1);
        end else begin
          n = $urandom_range(1, 4);
          repeat (n) send_request(8'($urandom_range(0, 255)), 1'b0);
        end
      end
    endcase
    if ($urandom_range(0, 1) == 0) send_request(rand_blank(), 1'b0);
  endtask

  task automatic random_text(int unsigned count);
    int unsigned goal;
    goal = requests_sent + count;
    while (requests_sent < goal) begin
      random_fragment();
      if ($urandom_range(0, 99) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    requests_sent = 0;
    sender_calm   = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: a word closed by a semicolon (two tokens from one
    // request), integer followed by a point, decimals in all three forms, a
    // lone point, braces, a directive with every allowed tail character,
    // every blank but the space, the lowest and highest bytes as other tokens,
    // and end of stream both with a token pending and with none.
    send_text("Zz9_;");
    send_request(stt_pkg::CHAR_TAB, 1'b0);
    send_text("07.");
    send_request(stt_pkg::CHAR_LF, 1'b0);
    send_text(".5{.}#a-_9");
    send_request(stt_pkg::CHAR_CR, 1'b0);
    send_request(stt_pkg::CHAR_FF, 1'b0);
    send_request(8'h00, 1'b0);
    send_request(8'hff, 1'b0);
    send_text("1.2");
    send_request(8'h80, 1'b1);
    send_text(".");
    send_request(8'h7f, 1'b1);
    send_text("#");
    send_request(8'h00, 1'b1);
    send_request(8'hff, 1'b1);
    wait_drained();

    random_text(560);
    random_text(560);
    send_request(8'($urandom_range(0, 255)), 1'b1);

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (tokens_owed != 0) @(negedge clk_i);
    // The wait goes on after the last owed token, to catch anything extra the
    // block might still put out.
    repeat (10) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("[source_text_tokenizer] OK");
    end else begin
      $display("[source_text_tokenizer] ERROR");
    end
    $finish;
  end

endmodule
